### hdl/pes_pkg.sv
// ----------------------------------------------------------------------------
// pes_pkg
// Shared constants and decode helpers for the PES header field parser.
// ----------------------------------------------------------------------------
package pes_pkg;

  localparam int POS_W = 6;

  localparam logic [23:0] START_CODE = 24'h000001;

  localparam logic [1:0] STATUS_OK         = 2'd0;
  localparam logic [1:0] STATUS_BAD_PREFIX = 2'd1;
  localparam logic [1:0] STATUS_BAD_FLAGS  = 2'd2;

  localparam logic [POS_W-1:0] POS_PREFIX_LAST = POS_W'(2);
  localparam logic [POS_W-1:0] POS_ID          = POS_W'(3);
  localparam logic [POS_W-1:0] POS_LEN_HI      = POS_W'(4);
  localparam logic [POS_W-1:0] POS_LEN_LO      = POS_W'(5);
  localparam logic [POS_W-1:0] POS_FLAGS_A     = POS_W'(6);
  localparam logic [POS_W-1:0] POS_FLAGS_B     = POS_W'(7);
  localparam logic [POS_W-1:0] POS_HDR_LEN     = POS_W'(8);
  localparam logic [POS_W-1:0] POS_OPT_FIRST   = POS_W'(9);

  localparam logic [POS_W-1:0] STAMP_BYTES = POS_W'(5);
  localparam logic [POS_W-1:0] ESCR_BYTES  = POS_W'(6);
  localparam logic [POS_W-1:0] RATE_BYTES  = POS_W'(3);
  localparam logic [POS_W-1:0] TRICK_BYTES = POS_W'(1);
  localparam logic [POS_W-1:0] COPY_BYTES  = POS_W'(1);

  localparam logic [POS_W-1:0] MAX_SECTION_END = POS_W'(30);

  localparam logic [1:0] PTS_DTS_FORBIDDEN = 2'b01;

  function automatic logic no_header(input logic [7:0] id);
    logic r;
    unique case (id) inside
      8'hBC, 8'hBD, 8'hBE, 8'hBF, 8'hF0, 8'hF1, 8'hF2, 8'hF8, 8'hFF: r = 1'b1;
      default: r = 1'b0;
    endcase
    return r;
  endfunction

  function automatic logic [POS_W-1:0] section_end_of(input logic [7:0] fb);
    logic [POS_W-1:0] e;
    e = POS_OPT_FIRST;
    if (fb[7])           e = e + STAMP_BYTES;
    if (fb[7] && fb[6])  e = e + STAMP_BYTES;
    if (fb[5])           e = e + ESCR_BYTES;
    if (fb[4])           e = e + RATE_BYTES;
    if (fb[3])           e = e + TRICK_BYTES;
    if (fb[2])           e = e + COPY_BYTES;
    return e;
  endfunction

  // one byte of a 33-bit time stamp, marker bits dropped
  function automatic logic [32:0] stamp_step(input logic [32:0] acc, input logic [2:0] j,
                                             input logic [7:0] b);
    logic [32:0] r;
    case (j)
      3'd0:       r = {30'b0, b[3:1]};
      3'd1, 3'd3: r = {acc[24:0], b};
      3'd2, 3'd4: r = {acc[25:0], b[7:1]};
      default:    r = acc;
    endcase
    return r;
  endfunction

endpackage

### hdl/pes_header_field_parser.sv
// ----------------------------------------------------------------------------
// pes_header_field_parser
// Byte-serial PES header parser: start code check, field capture, PTS/DTS,
// ES rate and additional copy info decode, one result per header.
// ----------------------------------------------------------------------------
// Input channel: in_valid/in_stall carry one packet byte (data_byte) per
// transaction; packet_start marks the first byte of a packet and abandons any
// packet in progress. Bytes without a start mark after a result are dropped.
// Output channel: out_valid/out_stall carry one result per header, sent when
// the header is complete or on a bad start code / forbidden PTS/DTS flags.
// Latency: the result is valid the cycle after its last header byte is taken.
// Throughput: one byte per cycle; each byte is decoded by a position compare
// and a shift into the capture registers, then the result register.
// A pending result does not block input: in_stall rises only when the result
// register is full and the receiver stalls it, and the result then holds.
// Reset: parser idles until a start mark, no result pending.
// ----------------------------------------------------------------------------
module pes_header_field_parser
  import pes_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [7:0]  data_byte,
  input  logic        packet_start,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [1:0]  status,
  output logic [7:0]  stream_id,
  output logic [15:0] packet_length,
  output logic        has_optional_header,
  output logic [5:0]  header_flags,
  output logic [7:0]  optional_flags,
  output logic [7:0]  header_data_length,
  output logic [32:0] pts_value,
  output logic [32:0] dts_value,
  output logic [21:0] es_rate,
  output logic [6:0]  copy_info
);

  logic [POS_W-1:0] byte_position, byte_position_next;
  logic [POS_W-1:0] section_end, section_end_next;
  logic             parse_done, parse_done_next;
  logic [23:0]      start_code_shift, start_code_shift_next;
  logic [7:0]       captured_id, captured_id_next;
  logic [15:0]      captured_length, captured_length_next;
  logic [5:0]       captured_flags_a, captured_flags_a_next;
  logic [7:0]       captured_flags_b, captured_flags_b_next;
  logic [7:0]       captured_header_length, captured_header_length_next;
  logic [32:0]      pts_accumulator, pts_accumulator_next;
  logic [32:0]      dts_accumulator, dts_accumulator_next;
  logic [21:0]      rate_accumulator, rate_accumulator_next;
  logic [6:0]       copy_capture, copy_capture_next;

  logic             accept, active, emit;
  logic [1:0]       status_next;
  logic [POS_W-1:0] p, p_inc, k, k_dts, k_rate;
  logic [POS_W-1:0] escr_base, rate_base, trick_base, copy_base;
  logic             pts_on, dts_on;

  assign in_stall = out_valid && out_stall;
  assign accept   = in_valid && !in_stall;
  assign active   = packet_start || !parse_done;

  // optional field layout from the flag byte
  always_comb begin
    pts_on     = captured_flags_b[7];
    dts_on     = captured_flags_b[7] && captured_flags_b[6];
    escr_base  = (pts_on ? STAMP_BYTES : '0) + (dts_on ? STAMP_BYTES : '0);
    rate_base  = escr_base + (captured_flags_b[5] ? ESCR_BYTES : '0);
    trick_base = rate_base + (captured_flags_b[4] ? RATE_BYTES : '0);
    copy_base  = trick_base + (captured_flags_b[3] ? TRICK_BYTES : '0);
  end

  always_comb begin
    p     = packet_start ? '0 : byte_position;
    p_inc = p + POS_W'(1);
    k      = p - POS_OPT_FIRST;
    k_dts  = k - STAMP_BYTES;
    k_rate = k - rate_base;

    section_end_next            = packet_start ? '0 : section_end;
    start_code_shift_next       = packet_start ? '0 : start_code_shift;
    captured_id_next            = packet_start ? '0 : captured_id;
    captured_length_next        = packet_start ? '0 : captured_length;
    captured_flags_a_next       = packet_start ? '0 : captured_flags_a;
    captured_flags_b_next       = packet_start ? '0 : captured_flags_b;
    captured_header_length_next = packet_start ? '0 : captured_header_length;
    pts_accumulator_next        = packet_start ? '0 : pts_accumulator;
    dts_accumulator_next        = packet_start ? '0 : dts_accumulator;
    rate_accumulator_next       = packet_start ? '0 : rate_accumulator;
    copy_capture_next           = packet_start ? '0 : copy_capture;
    byte_position_next          = p_inc;
    status_next                 = STATUS_OK;
    emit                        = 1'b0;

    case (p)
      '0, POS_W'(1), POS_PREFIX_LAST: begin
        start_code_shift_next = {start_code_shift_next[15:0], data_byte};
        if (p == POS_PREFIX_LAST && start_code_shift_next != START_CODE) begin
          status_next = STATUS_BAD_PREFIX;
          emit        = 1'b1;
        end
      end
      POS_ID:     captured_id_next = data_byte;
      POS_LEN_HI: captured_length_next = {data_byte, 8'h00};
      POS_LEN_LO: begin
        captured_length_next = {captured_length_next[15:8], data_byte};
        emit = no_header(captured_id_next);
      end
      POS_FLAGS_A: captured_flags_a_next = data_byte[5:0];
      POS_FLAGS_B: begin
        captured_flags_b_next = data_byte;
        if (data_byte[7:6] == PTS_DTS_FORBIDDEN) begin
          status_next = STATUS_BAD_FLAGS;
          emit        = 1'b1;
        end
      end
      POS_HDR_LEN: begin
        captured_header_length_next = data_byte;
        section_end_next            = section_end_of(captured_flags_b);
        emit = (section_end_next == POS_OPT_FIRST);
      end
      default: begin
        if (pts_on && k < STAMP_BYTES) begin
          pts_accumulator_next = stamp_step(pts_accumulator, k[2:0], data_byte);
        end
        if (dts_on && k >= STAMP_BYTES && k_dts < STAMP_BYTES) begin
          dts_accumulator_next = stamp_step(dts_accumulator, k_dts[2:0], data_byte);
        end
        if (captured_flags_b[4] && k >= rate_base && k_rate < RATE_BYTES) begin
          case (k_rate[1:0])
            2'd0:    rate_accumulator_next = {15'b0, data_byte[6:0]};
            2'd1:    rate_accumulator_next = {rate_accumulator[13:0], data_byte};
            2'd2:    rate_accumulator_next = {rate_accumulator[14:0], data_byte[7:1]};
            default: rate_accumulator_next = rate_accumulator;
          endcase
        end
        if (captured_flags_b[2] && k == copy_base) begin
          copy_capture_next = data_byte[6:0];
        end
        emit = (p_inc >= section_end);
      end
    endcase

    parse_done_next = emit;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      parse_done    <= 1'b1;
      byte_position <= '0;
    end else if (accept && active) begin
      parse_done    <= parse_done_next;
      byte_position <= byte_position_next;
    end
  end

  always_ff @(posedge clk) begin
    if (accept && active) begin
      section_end            <= section_end_next;
      start_code_shift       <= start_code_shift_next;
      captured_id            <= captured_id_next;
      captured_length        <= captured_length_next;
      captured_flags_a       <= captured_flags_a_next;
      captured_flags_b       <= captured_flags_b_next;
      captured_header_length <= captured_header_length_next;
      pts_accumulator        <= pts_accumulator_next;
      dts_accumulator        <= dts_accumulator_next;
      rate_accumulator       <= rate_accumulator_next;
      copy_capture           <= copy_capture_next;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else begin
      out_valid <= (accept && active && emit) || (out_valid && out_stall);
    end
  end

  always_ff @(posedge clk) begin
    if (accept && active && emit) begin
      status              <= status_next;
      stream_id           <= captured_id_next;
      packet_length       <= captured_length_next;
      has_optional_header <= (status_next != STATUS_BAD_PREFIX) && !no_header(captured_id_next);
      header_flags        <= captured_flags_a_next;
      optional_flags      <= captured_flags_b_next;
      header_data_length  <= captured_header_length_next;
      pts_value           <= pts_accumulator_next;
      dts_value           <= dts_accumulator_next;
      es_rate             <= rate_accumulator_next;
      copy_info           <= copy_capture_next;
    end
  end

  a_result_from_transaction: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(in_valid && !in_stall))
    else $error("result appeared without an input transaction");

  a_idle_after_result: assert property (@(posedge clk) disable iff (rst)
    (accept && active && emit) |=> parse_done)
    else $error("parser not idle after a result");

  a_bad_prefix_fields: assert property (@(posedge clk) disable iff (rst)
    (out_valid && status == STATUS_BAD_PREFIX) |-> (!has_optional_header && stream_id == 8'h00))
    else $error("bad start code result carries header fields");

  a_position_bound: assert property (@(posedge clk) disable iff (rst)
    !parse_done |-> byte_position <= MAX_SECTION_END)
    else $error("byte position ran past the longest header");

endmodule

### tb/sv/pes_header_checker.sv
// ----------------------------------------------------------------------------
// pes_header_checker
// Watches both channels of the PES header field parser, tracks the header
// parse byte by byte on every accepted input transaction and compares each
// accepted result transaction, field by field, with the oldest pending header.
// ----------------------------------------------------------------------------
module pes_header_checker
  import pes_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  input  logic        in_stall,
  input  logic [7:0]  data_byte,
  input  logic        packet_start,
  input  logic        out_valid,
  input  logic        out_stall,
  input  logic [1:0]  status,
  input  logic [7:0]  stream_id,
  input  logic [15:0] packet_length,
  input  logic        has_optional_header,
  input  logic [5:0]  header_flags,
  input  logic [7:0]  optional_flags,
  input  logic [7:0]  header_data_length,
  input  logic [32:0] pts_value,
  input  logic [32:0] dts_value,
  input  logic [21:0] es_rate,
  input  logic [6:0]  copy_info,
  output int          mismatches,
  output int          outstanding
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    logic [1:0]  status;
    logic [7:0]  stream_id;
    logic [15:0] packet_length;
    logic        has_optional_header;
    logic [5:0]  header_flags;
    logic [7:0]  optional_flags;
    logic [7:0]  header_data_length;
    logic [32:0] pts_value;
    logic [32:0] dts_value;
    logic [21:0] es_rate;
    logic [6:0]  copy_info;
  } pes_header_t;

  pes_header_t expected_headers[$];
  pes_header_t capture;
  pes_header_t oldest;
  logic [5:0]  byte_index;
  logic [5:0]  header_end;
  logic        waiting_start;
  logic [23:0] prefix_sr;

  function automatic logic plain_stream(input logic [7:0] id);
    case (id)
      8'hBC, 8'hBD, 8'hBE, 8'hBF, 8'hF0, 8'hF1, 8'hF2, 8'hF8, 8'hFF: return 1'b1;
      default: return 1'b0;
    endcase
  endfunction

  function automatic logic [5:0] header_end_for(input logic [7:0] fb);
    int n;
    n = int'(POS_OPT_FIRST);
    if (fb[7]) n += int'(STAMP_BYTES);
    if (fb[7:6] == 2'b11) n += int'(STAMP_BYTES);
    if (fb[5]) n += int'(ESCR_BYTES);
    if (fb[4]) n += int'(RATE_BYTES);
    if (fb[3]) n += int'(TRICK_BYTES);
    if (fb[2]) n += int'(COPY_BYTES);
    return 6'(n);
  endfunction

  // marker bits dropped: 3 + 8 + 7 + 8 + 7 bits
  function automatic logic [32:0] stamp_next(input logic [32:0] acc, input int k,
                                             input logic [7:0] b);
    case (k)
      0:       return {30'b0, b[3:1]};
      1, 3:    return {acc[24:0], b};
      default: return {acc[25:0], b[7:1]};
    endcase
  endfunction

  task automatic take_optional(input int k, input logic [7:0] b);
    logic [7:0] fb;
    fb = capture.optional_flags;
    if (fb[7]) begin
      if (k < STAMP_BYTES) begin
        capture.pts_value = stamp_next(capture.pts_value, k, b);
        return;
      end
      k -= STAMP_BYTES;
      if (fb[6]) begin
        if (k < STAMP_BYTES) begin
          capture.dts_value = stamp_next(capture.dts_value, k, b);
          return;
        end
        k -= STAMP_BYTES;
      end
    end
    if (fb[5]) begin
      if (k < ESCR_BYTES) return;
      k -= ESCR_BYTES;
    end
    if (fb[4]) begin
      if (k < RATE_BYTES) begin
        case (k)
          0:       capture.es_rate = {15'b0, b[6:0]};
          1:       capture.es_rate = {capture.es_rate[13:0], b};
          default: capture.es_rate = {capture.es_rate[14:0], b[7:1]};
        endcase
        return;
      end
      k -= RATE_BYTES;
    end
    if (fb[3]) begin
      if (k < TRICK_BYTES) return;
      k -= TRICK_BYTES;
    end
    if (fb[2] && k == 0) capture.copy_info = b[6:0];
  endtask

  task automatic parse_pes_byte(input logic [7:0] b, input logic s);
    logic       done;
    logic [1:0] code;
    done = 1'b0;
    code = STATUS_OK;
    if (s) begin
      capture       = '0;
      prefix_sr     = '0;
      byte_index    = '0;
      header_end    = '0;
      waiting_start = 1'b0;
    end else if (waiting_start) begin
      return;
    end
    case (byte_index)
      6'd0, 6'd1, POS_PREFIX_LAST: begin
        prefix_sr = {prefix_sr[15:0], b};
        if (byte_index == POS_PREFIX_LAST && prefix_sr != START_CODE) begin
          code = STATUS_BAD_PREFIX;
          done = 1'b1;
        end
      end
      POS_ID:     capture.stream_id = b;
      POS_LEN_HI: capture.packet_length[15:8] = b;
      POS_LEN_LO: begin
        capture.packet_length[7:0] = b;
        done = plain_stream(capture.stream_id);
      end
      POS_FLAGS_A: capture.header_flags = b[5:0];
      POS_FLAGS_B: begin
        capture.optional_flags = b;
        if (b[7:6] == PTS_DTS_FORBIDDEN) begin
          code = STATUS_BAD_FLAGS;
          done = 1'b1;
        end
      end
      POS_HDR_LEN: begin
        capture.header_data_length = b;
        header_end = header_end_for(capture.optional_flags);
        done = (header_end == POS_OPT_FIRST);
      end
      default: begin
        take_optional(int'(byte_index) - int'(POS_OPT_FIRST), b);
        done = (int'(byte_index) + 1 >= int'(header_end));
      end
    endcase
    byte_index = byte_index + 6'd1;
    if (done) begin
      waiting_start = 1'b1;
      capture.status = code;
      capture.has_optional_header =
        !(code == STATUS_BAD_PREFIX || plain_stream(capture.stream_id));
      expected_headers.push_back(capture);
    end
  endtask

  task automatic check_field(input string name, input logic [32:0] want,
                             input logic [32:0] got);
    if (want !== got) begin
      mismatches++;
      $display("%0t ns: %s expected 0x%0h, got 0x%0h", $time, name, want, got);
    end
  endtask

  always @(posedge clk) begin
    if (rst) begin
      expected_headers.delete();
      capture       = '0;
      prefix_sr     = '0;
      byte_index    = '0;
      header_end    = '0;
      waiting_start = 1'b1;
    end else begin
      if (out_valid && !out_stall) begin
        if (expected_headers.size() == 0) begin
          mismatches++;
          $display("%0t ns: result transaction with none expected, stream_id 0x%0h",
                   $time, stream_id);
        end else begin
          oldest = expected_headers.pop_front();
          check_field("status", oldest.status, status);
          check_field("stream_id", oldest.stream_id, stream_id);
          check_field("packet_length", oldest.packet_length, packet_length);
          check_field("has_optional_header", oldest.has_optional_header,
                      has_optional_header);
          check_field("header_flags", oldest.header_flags, header_flags);
          check_field("optional_flags", oldest.optional_flags, optional_flags);
          check_field("header_data_length", oldest.header_data_length,
                      header_data_length);
          check_field("pts_value", oldest.pts_value, pts_value);
          check_field("dts_value", oldest.dts_value, dts_value);
          check_field("es_rate", oldest.es_rate, es_rate);
          check_field("copy_info", oldest.copy_info, copy_info);
        end
      end
      if (in_valid && !in_stall) parse_pes_byte(data_byte, packet_start);
    end
    outstanding = expected_headers.size();
  end

endmodule

### tb/sv/testbench.sv
// ----------------------------------------------------------------------------
// testbench
// Drives PES packet bytes into the header field parser: a few directed
// headers, then random well-formed headers with random content mixed with bad
// start codes, forbidden flags, cut-off packets and stray bytes, under phases
// of sender gaps and receiver stalls. The checker judges every result.
// ----------------------------------------------------------------------------
module testbench;
  timeunit 1ns;
  timeprecision 1ps;
  import pes_pkg::*;

  localparam int TARGET_BYTES = 1050;
  localparam int CYCLE_LIMIT  = 200000;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic [7:0]  data_byte = 8'h00;
  logic        packet_start = 1'b0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic [1:0]  status;
  logic [7:0]  stream_id;
  logic [15:0] packet_length;
  logic        has_optional_header;
  logic [5:0]  header_flags;
  logic [7:0]  optional_flags;
  logic [7:0]  header_data_length;
  logic [32:0] pts_value;
  logic [32:0] dts_value;
  logic [21:0] es_rate;
  logic [6:0]  copy_info;

  int mismatches;
  int outstanding;
  int tx_idle_pct = 0;
  int rx_stall_pct = 0;
  int bytes_sent = 0;
  int cycle_count = 0;

  logic [8:0] packet_q[$];

  pes_header_field_parser uut (.*);

  pes_header_checker checker_i (.*);

  initial begin
    forever #5 clk = ~clk;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("FAIL pes_header_field_parser");
      $finish;
    end
  end

  always @(posedge clk) begin
    out_stall <= (rx_stall_pct != 0) && ($urandom_range(99) < rx_stall_pct);
  end

  function automatic logic [7:0] rand_byte();
    case ($urandom_range(9))
      0:       return 8'h00;
      1:       return 8'hFF;
      default: return 8'($urandom_range(255));
    endcase
  endfunction

  function automatic logic [7:0] plain_id();
    case ($urandom_range(8))
      0:       return 8'hBC;
      1:       return 8'hBD;
      2:       return 8'hBE;
      3:       return 8'hBF;
      4:       return 8'hF0;
      5:       return 8'hF1;
      6:       return 8'hF2;
      7:       return 8'hF8;
      default: return 8'hFF;
    endcase
  endfunction

  task automatic send_byte(input logic [7:0] b, input logic s);
    while (tx_idle_pct != 0 && $urandom_range(99) < tx_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid     <= 1'b1;
    data_byte    <= b;
    packet_start <= s;
    @(posedge clk);
    while (in_stall) @(posedge clk);
  endtask

  task automatic send_queue();
    foreach (packet_q[i]) send_byte(packet_q[i][7:0], packet_q[i][8]);
    packet_q.delete();
  endtask

  // full header with random optional bytes, cut to stop bytes when stop > 0
  task automatic queue_header(input logic [7:0] id, input logic [15:0] len,
                              input logic [7:0] b6, input logic [7:0] flags,
                              input logic [7:0] hdr_len, input int stop);
    int n_opt;
    int base;
    base  = packet_q.size();
    n_opt = (flags[7] ? 5 : 0) + (flags[7:6] == 2'b11 ? 5 : 0) + (flags[5] ? 6 : 0)
            + (flags[4] ? 3 : 0) + (flags[3] ? 1 : 0) + (flags[2] ? 1 : 0);
    packet_q.push_back({1'b1, START_CODE[23:16]});
    packet_q.push_back({1'b0, START_CODE[15:8]});
    packet_q.push_back({1'b0, START_CODE[7:0]});
    packet_q.push_back({1'b0, id});
    packet_q.push_back({1'b0, len[15:8]});
    packet_q.push_back({1'b0, len[7:0]});
    packet_q.push_back({1'b0, b6});
    packet_q.push_back({1'b0, flags});
    packet_q.push_back({1'b0, hdr_len});
    repeat (n_opt) packet_q.push_back({1'b0, rand_byte()});
    if (stop > 0)
      while (packet_q.size() > base + stop) void'(packet_q.pop_back());
  endtask

  task automatic build_packet();
    int         kind;
    int         keep;
    logic [1:0] pd;
    logic [7:0] flags;
    kind = $urandom_range(99);
    case ($urandom_range(2))
      0:       pd = 2'b00;
      1:       pd = 2'b10;
      default: pd = 2'b11;
    endcase
    flags = {pd, ($urandom_range(7) == 0) ? 6'h3F : 6'($urandom_range(63))};
    if (kind >= 94) begin
      // stray bytes with no start mark
      repeat ($urandom_range(1, 4)) packet_q.push_back({1'b0, rand_byte()});
      return;
    end
    if (kind >= 86) begin
      packet_q.push_back({1'b1, rand_byte()});
      packet_q.push_back({1'b0, rand_byte()});
      packet_q.push_back({1'b0, rand_byte()});
    end else if (kind >= 78) begin
      queue_header(rand_byte(), 16'($urandom), rand_byte(),
                   {PTS_DTS_FORBIDDEN, 6'($urandom_range(63))}, rand_byte(), 0);
    end else if ($urandom_range(3) == 0) begin
      queue_header(plain_id(), 16'($urandom), 8'h00, 8'h00, 8'h00, 6);
    end else begin
      queue_header(rand_byte(), 16'($urandom), rand_byte(), flags, rand_byte(), 0);
    end
    if (kind >= 70 && kind < 78) begin
      // cut off, the next start mark abandons it
      keep = $urandom_range(1, packet_q.size() - 1);
      while (packet_q.size() > keep) void'(packet_q.pop_back());
    end
    bytes_sent += packet_q.size();
    if (kind < 70 && $urandom_range(3) == 0)
      repeat ($urandom_range(1, 4)) packet_q.push_back({1'b0, rand_byte()});
  endtask

  initial begin
    repeat (7) @(posedge clk);
    rst <= 1'b0;

    // bad start code
    packet_q.push_back({1'b1, 8'h00});
    packet_q.push_back({1'b0, 8'h00});
    packet_q.push_back({1'b0, 8'h02});
    // stream without optional header
    queue_header(8'hBD, 16'hFFFF, 8'h00, 8'h00, 8'h00, 6);
    // forbidden pts/dts flags
    queue_header(8'hE0, 16'h0000, 8'h80, {PTS_DTS_FORBIDDEN, 6'h00}, 8'h00, 8);
    // no optional fields, crc and extension flags only
    queue_header(8'hC0, 16'h1234, 8'hBF, 8'h03, 8'h00, 0);
    bytes_sent += packet_q.size();
    send_queue();

    for (int phase = 0; phase < 4; phase++) begin
      case (phase)
        0: begin
          tx_idle_pct  = 0;
          rx_stall_pct = 0;
        end
        1: begin
          tx_idle_pct  = 74;
          rx_stall_pct = 0;
        end
        2: begin
          tx_idle_pct  = 0;
          rx_stall_pct = 74;
        end
        default: begin
          tx_idle_pct  = 26;
          rx_stall_pct = 26;
        end
      endcase
      while (bytes_sent < (phase + 1) * TARGET_BYTES / 4) begin
        build_packet();
        send_queue();
      end
    end

    in_valid <= 1'b0;
    @(posedge clk);
    wait (outstanding == 0);
    repeat (5) @(posedge clk);
    if (mismatches == 0 && outstanding == 0) begin
      $display("PASS pes_header_field_parser");
    end else begin
      $display("FAIL pes_header_field_parser");
    end
    $finish;
  end

endmodule
